/* rtl/hm_pkg.sv */
// Shared types and constants of the process CPU health monitor.
package hm_pkg;

	localparam int DIV_W = 32;

	localparam logic [6:0] PCT_CAP     = 7'd100;
	localparam logic [6:0] PCT_CRIT    = 7'd90;
	localparam logic [6:0] PCT_WARN    = 7'd70;
	localparam logic [6:0] PCT_SCALE   = 7'd100;
	localparam logic [7:0] STARV_WARN  = 8'd3;
	localparam logic [7:0] STARV_BOOST = 8'd3;
	localparam logic [7:0] STARV_MAX   = 8'd255;
	localparam logic [31:0] WINDOW_RESET = 32'd100;

	localparam logic [1:0] LVL_OK   = 2'd0;
	localparam logic [1:0] LVL_WARN = 2'd1;
	localparam logic [1:0] LVL_CRIT = 2'd2;

	typedef struct packed {
		logic        first_of_batch;
		logic [31:0] now;
		logic [2:0]  slot;
		logic [15:0] proc_id;
		logic [31:0] proc_ticks;
		logic        runnable;
	} sample_t;

	typedef struct packed {
		logic        taken;
		logic [2:0]  out_slot;
		logic [15:0] out_proc_id;
		logic [6:0]  cpu_percent;
		logic [31:0] ticks_in_window;
		logic [1:0]  health;
		logic [7:0]  starved_windows;
		logic        boost_request;
		logic [31:0] anomaly_count;
		logic [31:0] window_count;
	} result_t;

	// one slot's state word
	typedef struct packed {
		logic [31:0] last_ticks;
		logic [7:0]  starv;
		logic [1:0]  health;
	} slot_entry_t;

	typedef struct packed {
		logic rd;
		logic wr;
	} mem_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

/* rtl/hm_div.sv */
// Radix-2 restoring divider, one quotient bit per cycle.
module hm_div (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [31:0]            dividend,
	input  logic [31:0]            divisor,
	output logic [31:0]            quotient,
	output hm_pkg::div_stat_t      stat
);
	import hm_pkg::*;

	localparam int CNT_W = $clog2(DIV_W + 1);

	logic [31:0]      rem_q;
	logic [31:0]      quo_q;
	logic [31:0]      dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [33:0]      diff;
	logic             ge;

	// trial subtract of the shifted remainder
	assign diff = {1'b0, rem_q, quo_q[DIV_W-1]} - {2'b00, dvs_q};
	assign ge   = ~diff[33];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIV_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[31:0] : {rem_q[30:0], quo_q[DIV_W-1]};
			quo_q <= {quo_q[30:0], ge};
		end
	end

	assign quotient  = quo_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

/* rtl/hm_slot_mem.sv */
// Per-slot state memory with valid bits standing in for the cleared reset value.
module hm_slot_mem #(
	parameter int SLOT_COUNT = 8,
	localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  hm_pkg::mem_req_t    req,
	input  logic [IDX_W-1:0]    addr,
	input  hm_pkg::slot_entry_t wr_data,
	output hm_pkg::slot_entry_t rd_data
);
	import hm_pkg::*;

	slot_entry_t             mem [SLOT_COUNT];
	logic [SLOT_COUNT-1:0]   valid_q;
	slot_entry_t             rd_q;
	logic                    rd_valid_q;

	always_ff @(posedge clk) begin
		if (req.wr) begin
			mem[addr] <= wr_data;
		end
		if (req.rd) begin
			rd_q <= mem[addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (req.wr) begin
				valid_q[addr] <= 1'b1;
			end
			if (req.rd) begin
				rd_valid_q <= valid_q[addr];
			end
		end
	end

	// never-written entry reads as all zero
	assign rd_data = rd_valid_q ? rd_q : '0;

endmodule

/* rtl/process_cpu_health_monitor.sv */
// Top level of the process CPU health monitor: control sequencer, window state, result register.
//
//  channel  | handshake                   | payload             | moves
//  ---------+-----------------------------+---------------------+---------------------------
//  sample   | sample_valid / sample_ready | sample (sample_t)   | one process sample request
//  result   | result_valid / result_ready | result (result_t)   | one result per request
//  cfg      | cfg_wr_en (no wait)         | cfg_wr_data         | window length write
//
// Flow: a taken sample passes from accept to the result register through the slot memory
//   read, the divider steps, the divider done flag and the finish state; a skipped sample
//   goes straight to finish. The shared 32-bit restoring divider paces the taken ones. One request is in work.
// Reset: arst_n clears the window/anomaly totals, the slot valid bits and sets the window
//   length to 100; no clearing pass, the slot state is usable at once.
// Stalls: the result register holds while result_ready is low; a new request may be
//   accepted meanwhile, and its result waits for the register to free.
module process_cpu_health_monitor #(
	parameter int SLOT_COUNT = 8
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            sample_valid,
	output logic            sample_ready,
	input  hm_pkg::sample_t sample,
	output logic            result_valid,
	input  logic            result_ready,
	output hm_pkg::result_t result,
	input  logic            cfg_wr_en,
	input  logic [31:0]     cfg_wr_data
);
	import hm_pkg::*;

	localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_READ = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_FIN  = 4'b1000
	} state_t;

	state_t      state_q, state_d;

	// window bookkeeping
	logic [31:0] win_len_q;
	logic [31:0] last_start_q;
	logic [31:0] windows_q;
	logic [31:0] anomalies_q;
	logic        skipped_q;

	// request under work
	sample_t     item_q;
	logic        take_q;
	logic [31:0] delta_q;
	logic [7:0]  starv_q;
	logic [1:0]  oldh_q;

	// result register
	logic        out_valid_q;
	result_t     out_q;

	logic        accept;
	logic        out_free;
	logic        win_short;
	logic        skip_now;
	logic        slot_ok;
	logic        take_now;
	logic        finish;

	mem_req_t    mem_req;
	logic [IDX_W-1:0] mem_addr;
	slot_entry_t mem_wr;
	slot_entry_t mem_rd;

	logic [31:0] delta;
	logic [31:0] prod;
	logic [7:0]  starv_new;
	logic        div_start;
	logic [31:0] quotient;
	div_stat_t   div_stat;

	logic [6:0]  pct;
	logic [1:0]  newh;
	logic        boost;
	logic        rise;
	logic [31:0] anom_next;
	result_t     res_d;

	assign sample_ready = (state_q == ST_IDLE);
	assign accept       = sample_valid & sample_ready;
	assign out_free     = ~out_valid_q | result_ready;
	assign finish       = (state_q == ST_FIN) & out_free;

	// window check happens on the first sample of a batch; the skip flag holds for the rest
	assign win_short = (sample.now - last_start_q) < win_len_q;
	assign skip_now  = sample.first_of_batch ? win_short : skipped_q;
	assign slot_ok   = 7'(sample.slot) < 7'(SLOT_COUNT);
	assign take_now  = ~skip_now & slot_ok;

	// read at accept, write back when the result is stored
	assign mem_req.rd = accept & take_now;
	assign mem_req.wr = finish & take_q;
	assign mem_addr   = (state_q == ST_IDLE) ? IDX_W'(sample.slot) : IDX_W'(item_q.slot);

	hm_slot_mem #(
		.SLOT_COUNT(SLOT_COUNT)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (mem_req),
		.addr    (mem_addr),
		.wr_data (mem_wr),
		.rd_data (mem_rd)
	);

	// read stage: tick delta, scaled by 100 mod 2^32, and the new starvation count
	assign delta     = item_q.proc_ticks - mem_rd.last_ticks;
	assign prod      = delta * 32'(PCT_SCALE);
	assign div_start = (state_q == ST_READ);

	always_comb begin
		if (item_q.runnable && (delta == '0)) begin
			starv_new = (mem_rd.starv == STARV_MAX) ? STARV_MAX : mem_rd.starv + 8'd1;
		end else begin
			starv_new = '0;
		end
	end

	hm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (prod),
		.divisor  (win_len_q),
		.quotient (quotient),
		.stat     (div_stat)
	);

	// finish stage: cap, health class, anomaly count
	assign pct = (quotient > 32'(PCT_CAP)) ? PCT_CAP : quotient[6:0];

	always_comb begin
		if (pct > PCT_CRIT) begin
			newh = LVL_CRIT;
		end else if ((pct > PCT_WARN) || (starv_q > STARV_WARN)) begin
			newh = LVL_WARN;
		end else begin
			newh = LVL_OK;
		end
	end

	assign boost     = (starv_q >= STARV_BOOST);
	assign rise      = (newh > oldh_q);
	assign anom_next = anomalies_q + 32'(rise) + 32'(boost);

	assign mem_wr.last_ticks = item_q.proc_ticks;
	assign mem_wr.starv      = starv_q;
	assign mem_wr.health     = newh;

	always_comb begin
		res_d              = '0;
		res_d.out_slot     = item_q.slot;
		res_d.out_proc_id  = item_q.proc_id;
		res_d.window_count = windows_q;
		if (take_q) begin
			res_d.taken           = 1'b1;
			res_d.cpu_percent     = pct;
			res_d.ticks_in_window = delta_q;
			res_d.health          = newh;
			res_d.starved_windows = starv_q;
			res_d.boost_request   = boost;
			res_d.anomaly_count   = anom_next;
		end else begin
			res_d.anomaly_count   = anomalies_q;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = take_now ? ST_READ : ST_FIN;
				end
			end
			ST_READ: state_d = ST_DIV;
			ST_DIV: begin
				if (div_stat.done) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			win_len_q      <= WINDOW_RESET;
			last_start_q   <= '0;
			windows_q      <= '0;
			anomalies_q    <= '0;
			skipped_q      <= 1'b0;
			take_q         <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				win_len_q <= cfg_wr_data;
			end
			if (accept) begin
				take_q <= take_now;
				if (sample.first_of_batch) begin
					skipped_q <= win_short;
					if (!win_short) begin
						last_start_q <= sample.now;
						windows_q    <= windows_q + 32'd1;
					end
				end
			end
			if (finish && take_q) begin
				anomalies_q <= anom_next;
			end
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= sample;
		end
		if (state_q == ST_READ) begin
			delta_q <= delta;
			starv_q <= starv_new;
			oldh_q  <= mem_rd.health;
		end
		if (finish) begin
			out_q <= res_d;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

/* rtl/hm_checker.sv */
// Port-level checks of the health monitor result channel, bound to the top level.
module hm_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            result_valid,
	input logic            result_ready,
	input hm_pkg::result_t result
);
	import hm_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	a_skip_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.taken |-> result.cpu_percent == '0 &&
			result.ticks_in_window == '0 && result.health == LVL_OK &&
			result.starved_windows == '0 && !result.boost_request)
		else $error("skipped result carries nonzero fields");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.cpu_percent <= PCT_CAP && result.health != 2'd3)
		else $error("percent or health out of range");

	a_boost: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.taken |->
			result.boost_request == (result.starved_windows >= STARV_BOOST))
		else $error("boost request disagrees with starvation count");

	a_crit: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.taken |->
			(result.health == LVL_CRIT) == (result.cpu_percent > PCT_CRIT))
		else $error("critical health disagrees with percent");

endmodule

bind process_cpu_health_monitor hm_checker u_hm_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result       (result)
);

/* tb/process_cpu_health_monitor_tb.sv */
// Self-checking testbench for the process CPU health monitor.
`timescale 1ns / 100ps

module process_cpu_health_monitor_tb;
	import hm_pkg::*;

	localparam int SLOTS = 8;
	localparam int SHOW_MAX = 10;

	// ------------------------------------------------------------------
	// DUT signals; every input is known from time zero
	// ------------------------------------------------------------------
	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        sample_valid = 1'b0;
	logic        sample_ready;
	sample_t     sample = '0;
	logic        result_valid;
	logic        result_ready = 1'b0;
	result_t     result;
	logic        cfg_wr_en = 1'b0;
	logic [31:0] cfg_wr_data = '0;

	process_cpu_health_monitor #(
		.SLOT_COUNT(SLOTS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_ready(sample_ready),
		.sample(sample),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	// ------------------------------------------------------------------
	// Monitor state as the testbench sees it
	// ------------------------------------------------------------------
	logic [31:0] window_len;
	logic [31:0] win_start;
	logic [31:0] windows_seen;
	logic [31:0] anomalies_seen;
	logic        batch_off;
	logic [31:0] slot_last_ticks [SLOTS];
	logic [7:0]  slot_starv [SLOTS];
	logic [1:0]  slot_level [SLOTS];

	result_t     pending_results [$];

	int unsigned error_count = 0;
	int unsigned shown_count = 0;

	// idling control: no_idle turns off all random gaps, gaps_off only the sender's,
	// long_hold makes the receiver refuse results for that many cycles
	bit          no_idle = 1'b0;
	bit          gaps_off = 1'b0;
	int unsigned long_hold = 0;

	// ------------------------------------------------------------------
	// Clock and run limit
	// ------------------------------------------------------------------
	initial begin
		forever #10 clk = ~clk;
	end

	// run limit, well above the slowest legal run
	initial begin
		#40_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	// ------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------
	task automatic clear_monitor_state();
		window_len = WINDOW_RESET;
		win_start = '0;
		windows_seen = '0;
		anomalies_seen = '0;
		batch_off = 1'b0;
		for (int i = 0; i < SLOTS; i++) begin
			slot_last_ticks[i] = '0;
			slot_starv[i] = '0;
			slot_level[i] = LVL_OK;
		end
	endtask

	// Works out the result of one accepted request and advances the state.
	function automatic result_t predict_sample(sample_t s);
		result_t     r;
		logic [31:0] since;
		logic [31:0] delta;
		logic [31:0] prod;
		logic [31:0] pct;
		logic [7:0]  starv;
		logic [1:0]  new_level;
		logic [1:0]  old_level;
		logic        boost;
		int          idx;

		// window check only on the first request of a batch
		if (s.first_of_batch) begin
			since = s.now - win_start;
			if (since < window_len) begin
				batch_off = 1'b1;
			end else begin
				batch_off = 1'b0;
				win_start = s.now;
				windows_seen = windows_seen + 32'd1;
			end
		end

		r = '0;
		r.out_slot = s.slot;
		r.out_proc_id = s.proc_id;
		r.window_count = windows_seen;

		// skipped request: totals only, nothing else moves
		if (batch_off || s.slot >= SLOTS) begin
			r.anomaly_count = anomalies_seen;
			return r;
		end

		idx = int'(s.slot);
		delta = s.proc_ticks - slot_last_ticks[idx];
		slot_last_ticks[idx] = s.proc_ticks;

		// product wraps at 32 bits before the divide; zero window reads as full load
		prod = delta * 32'(PCT_SCALE);
		if (window_len == 32'd0)
			pct = 32'(PCT_CAP);
		else
			pct = prod / window_len;
		if (pct > 32'(PCT_CAP))
			pct = 32'(PCT_CAP);

		starv = slot_starv[idx];
		if (s.runnable && delta == 32'd0) begin
			if (starv != STARV_MAX)
				starv = starv + 8'd1;
		end else begin
			starv = '0;
		end
		slot_starv[idx] = starv;

		old_level = slot_level[idx];
		if (pct > 32'(PCT_CRIT))
			new_level = LVL_CRIT;
		else if (pct > 32'(PCT_WARN) || starv > STARV_WARN)
			new_level = LVL_WARN;
		else
			new_level = LVL_OK;
		slot_level[idx] = new_level;

		if (new_level > old_level)
			anomalies_seen = anomalies_seen + 32'd1;
		boost = (starv >= STARV_BOOST);
		if (boost)
			anomalies_seen = anomalies_seen + 32'd1;

		r.taken = 1'b1;
		r.cpu_percent = pct[6:0];
		r.ticks_in_window = delta;
		r.health = new_level;
		r.starved_windows = starv;
		r.boost_request = boost;
		r.anomaly_count = anomalies_seen;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Result checking: oldest expectation against each accepted result
	// ------------------------------------------------------------------
	function automatic string show_result(result_t r);
		return $sformatf(
			"taken=%0d slot=%0d pid=%h pct=%0d ticks=%h health=%0d starv=%0d boost=%0d anom=%h win=%h",
			r.taken, r.out_slot, r.out_proc_id, r.cpu_percent, r.ticks_in_window,
			r.health, r.starved_windows, r.boost_request, r.anomaly_count, r.window_count);
	endfunction

	always @(posedge clk) begin
		result_t want;
		bit      bad;
		if (arst_n && result_valid && result_ready) begin
			if (pending_results.size() == 0) begin
				error_count++;
				if (shown_count < SHOW_MAX) begin
					shown_count++;
					$display("%0t: result with no request waiting: %s", $realtime,
						show_result(result));
				end
			end else begin
				want = pending_results.pop_front();
				bad = (result.taken !== want.taken) ||
					(result.out_slot !== want.out_slot) ||
					(result.out_proc_id !== want.out_proc_id) ||
					(result.cpu_percent !== want.cpu_percent) ||
					(result.ticks_in_window !== want.ticks_in_window) ||
					(result.health !== want.health) ||
					(result.starved_windows !== want.starved_windows) ||
					(result.boost_request !== want.boost_request) ||
					(result.anomaly_count !== want.anomaly_count) ||
					(result.window_count !== want.window_count);
				if (bad) begin
					error_count++;
					if (shown_count < SHOW_MAX) begin
						shown_count++;
						$display("%0t: mismatch\n  expected %s\n  actual   %s", $realtime,
							show_result(want), show_result(result));
					end
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Receiver: random stall bursts, plus a long hold-off when asked
	// ------------------------------------------------------------------
	initial begin
		int unsigned stall_left;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (long_hold > 0) begin
				long_hold--;
				result_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				result_ready <= 1'b0;
			end else if (!no_idle && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 18) - 1;
				result_ready <= 1'b0;
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Sender
	// ------------------------------------------------------------------
	function automatic sample_t make_sample(bit first, logic [31:0] now, logic [2:0] sl,
		logic [15:0] pid, logic [31:0] ticks, bit run);
		sample_t s;
		s.first_of_batch = first;
		s.now = now;
		s.slot = sl;
		s.proc_id = pid;
		s.proc_ticks = ticks;
		s.runnable = run;
		return s;
	endfunction

	// Offers one request, predicts it once accepted, then maybe idles a burst.
	// Valid stays high across back-to-back requests.
	task automatic offer_sample(sample_t s);
		int unsigned gap;
		@(negedge clk);
		sample <= s;
		sample_valid <= 1'b1;
		do
			@(posedge clk);
		while (!sample_ready);
		pending_results.push_back(predict_sample(s));
		if (!no_idle && !gaps_off && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 18);
			@(negedge clk);
			sample_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// Drop valid and hold off until every expected result has come back.
	task automatic wait_drained();
		@(negedge clk);
		sample_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// Register write, only with the block idle.
	task automatic set_window(logic [31:0] value);
		wait_drained();
		repeat (4) @(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		window_len = value;
	endtask

	// ------------------------------------------------------------------
	// Directed tests
	// ------------------------------------------------------------------

	// Requests ahead of any batch start run as if a window were open.
	task automatic test_before_batch();
		offer_sample(make_sample(1'b0, 32'h0, 3'd0, 16'h0000, 32'd50, 1'b0));
		// all-ones ticks: product wraps, percent caps
		offer_sample(make_sample(1'b0, 32'hFFFF_FFFF, 3'd7, 16'hFFFF, 32'hFFFF_FFFF, 1'b1));
	endtask

	// Early batch is skipped whole; an on-time batch runs the percent boundaries.
	task automatic test_window_check();
		offer_sample(make_sample(1'b1, 32'd99, 3'd1, 16'h1234, 32'd500, 1'b1));
		offer_sample(make_sample(1'b0, 32'd0, 3'd2, 16'h4321, 32'd600, 1'b1));
		offer_sample(make_sample(1'b1, 32'd100, 3'd1, 16'h0001, 32'd71, 1'b0));
		offer_sample(make_sample(1'b0, 32'd5, 3'd3, 16'h0002, 32'd70, 1'b0));
		offer_sample(make_sample(1'b0, 32'd5, 3'd4, 16'h0003, 32'd90, 1'b1));
		offer_sample(make_sample(1'b0, 32'd5, 3'd5, 16'h0004, 32'd91, 1'b0));
		offer_sample(make_sample(1'b0, 32'd5, 3'd2, 16'h0005, 32'd100, 1'b1));
	endtask

	// Runnable with zero delta: boost from three, warn above three, then clears.
	task automatic test_starvation();
		for (int i = 0; i < 5; i++)
			offer_sample(make_sample(1'b0, 32'd0, 3'd6, 16'h0600, 32'd0, 1'b1));
		offer_sample(make_sample(1'b0, 32'd0, 3'd6, 16'h0601, 32'd0, 1'b0));
		offer_sample(make_sample(1'b0, 32'd0, 3'd6, 16'h0602, 32'd1, 1'b1));
	endtask

	// Zero window: every check accepts and percent reads full.
	task automatic test_zero_window();
		set_window(32'd0);
		offer_sample(make_sample(1'b1, win_start, 3'd2, 16'h0A00, slot_last_ticks[2] + 32'd1,
			1'b1));
		offer_sample(make_sample(1'b0, 32'd0, 3'd3, 16'h0A01, slot_last_ticks[3], 1'b0));
		offer_sample(make_sample(1'b1, win_start, 3'd4, 16'h0A02, slot_last_ticks[4], 1'b1));
	endtask

	// Largest and smallest window lengths at their exact edges.
	task automatic test_window_extremes();
		set_window(32'hFFFF_FFFF);
		offer_sample(make_sample(1'b1, win_start + 32'd1, 3'd0, 16'h0B00, 32'd7, 1'b1));
		offer_sample(make_sample(1'b1, win_start + 32'hFFFF_FFFF, 3'd0, 16'h0B01,
			slot_last_ticks[0] + 32'h7FFF_FFFF, 1'b1));
		set_window(32'd1);
		offer_sample(make_sample(1'b1, win_start, 3'd1, 16'h0B02, 32'd3, 1'b1));
		offer_sample(make_sample(1'b1, win_start + 32'd1, 3'd1, 16'h0B03,
			slot_last_ticks[1] + 32'd1, 1'b0));
		set_window(WINDOW_RESET);
	endtask

	// One slot starved long enough for the count to saturate.
	task automatic test_starvation_saturation();
		set_window(32'd50);
		offer_sample(make_sample(1'b1, win_start + 32'd50, 3'd5, 16'h5500,
			slot_last_ticks[5] + 32'd10, 1'b1));
		for (int i = 0; i < 259; i++)
			offer_sample(make_sample(1'b0, $urandom, 3'd5, 16'($urandom), slot_last_ticks[5],
				1'b1));
	endtask

	// Receiver stops for a long stretch while requests keep coming back to back.
	task automatic test_backpressure();
		wait_drained();
		long_hold = 300;
		gaps_off = 1'b1;
		run_random(24);
		gaps_off = 1'b0;
		wait_drained();
	endtask

	// Sender stops mid-stream until every result is back, then carries on.
	task automatic test_sender_pause();
		run_random(15);
		wait_drained();
		run_random(15);
	endtask

	// ------------------------------------------------------------------
	// Random stimulus
	// ------------------------------------------------------------------

	// Tick delta scaled to the window so every percent band gets hit.
	function automatic logic [31:0] pick_delta(bit starving);
		int unsigned roll;
		longint      w;
		w = longint'(window_len);
		roll = $urandom_range(0, 99);
		if (roll < (starving ? 70 : 20))
			return 32'd0;
		if (window_len == 32'd0 || window_len > 32'h0100_0000 || roll >= 90)
			return $urandom;
		if (roll >= 80) begin
			case ($urandom_range(0, 4))
				0: return 32'(w * 70 / 100);
				1: return 32'(w * 71 / 100 + 1);
				2: return 32'(w * 90 / 100);
				3: return 32'(w * 91 / 100 + 1);
				default: return window_len;
			endcase
		end
		return $urandom_range(0, 32'(w + w / 4));
	endfunction

	// Mostly well-formed batches: a window-opening request followed by up to five samples;
	// some batches arrive early, and a tenth of the draws send a single pure-noise request.
	task automatic run_random(int unsigned count);
		int unsigned sent;
		int unsigned batch_len;
		int unsigned starve_slot;
		logic [31:0] step;
		logic [31:0] delta;
		logic [2:0]  sl;
		bit          run;
		sample_t     s;

		sent = 0;
		starve_slot = $urandom_range(0, SLOTS - 1);
		while (sent < count) begin
			if ($urandom_range(0, 99) < 10) begin
				s = make_sample(1'($urandom_range(0, 1)), $urandom, 3'($urandom_range(0, 7)),
					16'($urandom), $urandom, 1'($urandom_range(0, 1)));
				offer_sample(s);
				sent++;
			end else begin
				if (window_len == 32'd0 || $urandom_range(0, 99) < 85) begin
					if (window_len > 32'h0100_0000)
						step = window_len;
					else
						step = window_len + $urandom_range(0, window_len);
				end else begin
					step = $urandom_range(0, window_len - 32'd1);
				end
				batch_len = $urandom_range(1, 6);
				for (int k = 0; k < batch_len; k++) begin
					sl = 3'($urandom_range(0, SLOTS - 1));
					delta = pick_delta(sl == starve_slot);
					run = (delta == 32'd0) ? ($urandom_range(0, 9) < 8) :
						1'($urandom_range(0, 1));
					s = make_sample(k == 0, (k == 0) ? win_start + step : $urandom, sl,
						16'($urandom), slot_last_ticks[sl] + delta, run);
					offer_sample(s);
					sent++;
				end
			end
		end
	endtask

	task automatic test_random_window(logic [31:0] value, int unsigned count);
		set_window(value);
		run_random(count);
	endtask

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------
	initial begin
		clear_monitor_state();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_before_batch();
		test_window_check();
		test_starvation();
		test_zero_window();
		test_window_extremes();

		test_starvation_saturation();
		test_backpressure();
		test_sender_pause();

		test_random_window(WINDOW_RESET, 300);
		test_random_window(32'd1, 150);
		test_random_window($urandom_range(2, 5000), 300);
		test_random_window(32'd0, 100);
		test_random_window(32'hFFFF_FFFF, 40);

		// closing stretch at full rate on both sides
		no_idle = 1'b1;
		test_random_window(32'd1000, 200);

		wait_drained();
		repeat (50) @(posedge clk);
		if (error_count == 0 && pending_results.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
